// File: hdl/lst_pkg.sv
// ---------------------------------------------------------------------------
// lst_pkg
// Shared types and constants for the locomotive state table.
// ---------------------------------------------------------------------------
package lst_pkg;

    typedef enum logic [1:0] {
        CMD_QUERY  = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NEXT   = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOLIVE   = 2'd3;

    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_DRIVE = 3'd1;

    localparam logic [3:0] OP_DRIVE = 4'h1;
    localparam logic [3:0] OP_FUNC  = 4'hF;

    localparam logic       REG_ENTRIES = 1'b0;
    localparam logic       REG_RELOAD  = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] loco_address;
        logic [7:0]  op_byte;
        logic [7:0]  arg_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [15:0] out_address;
        logic [3:0]  out_flags;
        logic [7:0]  out_speed;
        logic [4:0]  func_byte0;
        logic [7:0]  func_byte1;
        logic [7:0]  func_byte2;
        logic [7:0]  func_byte3;
        logic [2:0]  send_kind;
        logic [4:0]  pending_groups;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_TICK,
        S_NEXT,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture item, clear scan
        logic scan_step; // advance search index
        logic write;     // apply update to matching or free slot
        logic tick_step; // age one entry
        logic next_step; // advance round-robin probe
        logic emit;      // drive result strobe
    } t_ctrl;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       scan_last;
        logic       next_done;
    } t_stat;

    // Send kind for a function index
    function automatic logic [2:0] func_kind(input logic [5:0] idx);
        if (idx < 6'd5)       return 3'd2;
        else if (idx < 6'd9)  return 3'd3;
        else if (idx < 6'd13) return 3'd4;
        else if (idx < 6'd21) return 3'd5;
        else                  return 3'd6;
    endfunction

endpackage

// File: hdl/lst_ctrl.sv
// ---------------------------------------------------------------------------
// lst_ctrl
// Command sequencer: scan, write, tick and round-robin steps.
// ---------------------------------------------------------------------------
module lst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  lst_pkg::t_stat i_stat,
    output lst_pkg::t_ctrl o_ctrl,
    output logic          o_busy
);
    import lst_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctrl.load = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                case (i_stat.cmd)
                    CMD_TICK: n_state = S_TICK;
                    CMD_NEXT: n_state = S_NEXT;
                    default: begin
                        o_ctrl.scan_step = 1'b1;
                        // Query and update both finish in the write cycle
                        if (i_stat.scan_last) begin
                            n_state = S_WRITE;
                        end
                    end
                endcase
            end
            S_WRITE: begin
                o_ctrl.write = 1'b1;
                n_state      = S_DONE;
            end
            S_TICK: begin
                o_ctrl.tick_step = 1'b1;
                if (i_stat.scan_last) n_state = S_DONE;
            end
            S_NEXT: begin
                o_ctrl.next_step = 1'b1;
                if (i_stat.next_done) n_state = S_DONE;
            end
            S_DONE: begin
                o_ctrl.emit = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: hdl/lst_datapath.sv
// ---------------------------------------------------------------------------
// lst_datapath
// Entry table, search and aging scan, round-robin pointer, result register.
// ---------------------------------------------------------------------------
module lst_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lst_pkg::t_ctrl    i_ctrl,
    input  lst_pkg::t_in_item i_item,
    input  logic [4:0]        i_entries,
    input  logic [7:0]        i_reload,
    output lst_pkg::t_stat    o_stat,
    output lst_pkg::t_out_item o_result
);
    import lst_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Entry storage; timer reset marks all entries free
    logic [15:0] r_addr  [TABLE_DEPTH];
    logic [3:0]  r_flags [TABLE_DEPTH];
    logic [7:0]  r_speed [TABLE_DEPTH];
    logic [31:0] r_func  [TABLE_DEPTH];
    logic [4:0]  r_pend  [TABLE_DEPTH];
    logic [7:0]  r_timer [TABLE_DEPTH];

    t_in_item    r_item;
    logic [CW-1:0] r_n;        // effective entry count
    logic [CW-1:0] r_idx;      // scan position
    logic [CW-1:0] r_steps;    // next probes done
    logic [IW-1:0] r_rr;
    logic [IW-1:0] r_pos;
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic          r_free;
    logic [IW-1:0] r_free_idx;
    logic          r_found;
    t_out_item     r_result;

    logic [CW-1:0] n_eff;
    logic [IW-1:0] cur;
    logic [CW-1:0] pos_inc;
    logic [IW-1:0] pos_nxt;
    logic [IW-1:0] rep;
    logic [31:0]   fv;
    logic [5:0]    fidx;
    logic [31:0]   fmask;
    logic [31:0]   nf;
    logic [4:0]    np;
    logic          capture;
    t_out_item     n_result;

    assign n_eff   = (int'(i_entries) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(i_entries);
    assign cur     = r_idx[IW-1:0];
    assign pos_inc = CW'(r_pos) + CW'(1);
    assign pos_nxt = (pos_inc >= r_n) ? '0 : pos_inc[IW-1:0];
    assign fidx    = r_item.arg_byte[5:0];
    assign fmask   = (fidx[5]) ? 32'd0 : (32'd1 << fidx[4:0]);

    assign o_stat.cmd       = r_item.command;
    assign o_stat.scan_last = (r_idx + CW'(1) >= r_n) || (r_n == '0);
    assign o_stat.next_done = r_found || (r_steps >= r_n);

    // Sequencing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rr    <= '0;
            r_found <= 1'b0;
        end else if (i_ctrl.load) begin
            r_item   <= i_item;
            r_n      <= n_eff;
            r_idx    <= '0;
            r_steps  <= '0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
            r_found  <= 1'b0;
            r_pos    <= r_rr;
        end else begin
            // Search one entry per cycle
            if (i_ctrl.scan_step || i_ctrl.tick_step) r_idx <= r_idx + CW'(1);
            if (i_ctrl.scan_step && r_n != '0) begin
                if (!r_hit && r_timer[cur] != 8'd0 && r_addr[cur] == r_item.loco_address) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= cur;
                end
                if (!r_free && r_timer[cur] == 8'd0) begin
                    r_free     <= 1'b1;
                    r_free_idx <= cur;
                end
            end
            // Probe one position per cycle
            if (i_ctrl.next_step && !r_found && r_steps < r_n) begin
                r_steps <= r_steps + CW'(1);
                r_pos   <= pos_nxt;
                if (r_timer[pos_nxt] != 8'd0) begin
                    r_found <= 1'b1;
                    r_rr    <= pos_nxt;
                end
            end
        end
    end

    // Table writes: update, tick aging
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                r_addr[k]  <= '0;
                r_flags[k] <= '0;
                r_speed[k] <= '0;
                r_func[k]  <= '0;
                r_pend[k]  <= '0;
                r_timer[k] <= '0;
            end
        end else begin
            if (i_ctrl.tick_step && r_n != '0 && r_timer[cur] != 8'd0)
                r_timer[cur] <= r_timer[cur] - 8'd1;
            if (i_ctrl.write && r_item.command == CMD_UPDATE && (r_hit || r_free)) begin
                r_timer[rep] <= i_reload;
                if (!r_hit) r_addr[rep] <= r_item.loco_address;
                if (r_item.op_byte[7:4] == OP_DRIVE) begin
                    r_flags[rep] <= r_item.op_byte[3:0];
                    r_speed[rep] <= r_item.arg_byte;
                end else if (r_item.op_byte[7:4] == OP_FUNC) begin
                    r_pend[rep] <= r_pend[rep] |
                                   (5'd1 << (func_kind(fidx) - 3'd2));
                    if (r_item.arg_byte[7])      r_func[rep] <= r_func[rep] ^ fmask;
                    else if (r_item.arg_byte[6]) r_func[rep] <= r_func[rep] | fmask;
                    else                         r_func[rep] <= r_func[rep] & ~fmask;
                end
            end
        end
    end

    // Entry whose fields are reported
    always_comb begin
        case (r_item.command)
            CMD_QUERY:  rep = r_hit_idx;
            CMD_UPDATE: rep = r_hit ? r_hit_idx : r_free_idx;
            default:    rep = r_rr;
        endcase
    end
    assign fv = r_func[rep];

    // Function bits and pending mask as they will be after a function update
    always_comb begin
        nf = fv;
        np = r_pend[rep];
        if (r_item.op_byte[7:4] == OP_FUNC) begin
            np = np | (5'd1 << (func_kind(fidx) - 3'd2));
            if (r_item.arg_byte[7])      nf = fv ^ fmask;
            else if (r_item.arg_byte[6]) nf = fv | fmask;
            else                         nf = fv & ~fmask;
        end
    end

    // Build the result for the current command
    always_comb begin
        n_result = '0;
        case (r_item.command)
            CMD_QUERY: begin
                if (r_hit) begin
                    n_result.slot           = 4'(rep);
                    n_result.out_address    = r_addr[rep];
                    n_result.out_flags      = r_flags[rep];
                    n_result.out_speed      = r_speed[rep];
                    n_result.func_byte0     = {fv[0], fv[4:1]};
                    n_result.func_byte1     = fv[12:5];
                    n_result.func_byte2     = fv[20:13];
                    n_result.func_byte3     = fv[28:21];
                    n_result.pending_groups = r_pend[rep];
                end else begin
                    n_result.status      = ST_NOTFOUND;
                    n_result.out_address = r_item.loco_address;
                    n_result.out_flags   = 4'h2;
                    n_result.out_speed   = 8'h80;
                end
            end
            CMD_UPDATE: begin
                n_result.out_address = r_item.loco_address;
                if (!(r_hit || r_free)) begin
                    n_result.status = ST_FULL;
                end else begin
                    // Report entry as it will be after the write
                    n_result.slot           = 4'(rep);
                    n_result.out_flags      = r_flags[rep];
                    n_result.out_speed      = r_speed[rep];
                    n_result.send_kind      = KIND_NONE;
                    if (r_item.op_byte[7:4] == OP_DRIVE) begin
                        n_result.out_flags = r_item.op_byte[3:0];
                        n_result.out_speed = r_item.arg_byte;
                        n_result.send_kind = KIND_DRIVE;
                    end else if (r_item.op_byte[7:4] == OP_FUNC) begin
                        n_result.send_kind = func_kind(fidx);
                    end
                    n_result.func_byte0     = {nf[0], nf[4:1]};
                    n_result.func_byte1     = nf[12:5];
                    n_result.func_byte2     = nf[20:13];
                    n_result.func_byte3     = nf[28:21];
                    n_result.pending_groups = np;
                end
            end
            CMD_NEXT: begin
                if (r_found) begin
                    n_result.slot           = 4'(rep);
                    n_result.out_address    = r_addr[rep];
                    n_result.out_flags      = r_flags[rep];
                    n_result.out_speed      = r_speed[rep];
                    n_result.func_byte0     = {fv[0], fv[4:1]};
                    n_result.func_byte1     = fv[12:5];
                    n_result.func_byte2     = fv[20:13];
                    n_result.func_byte3     = fv[28:21];
                    n_result.pending_groups = r_pend[rep];
                end else begin
                    n_result.status = ST_NOLIVE;
                    n_result.slot   = 4'(r_rr);
                end
            end
            default: ;
        endcase
    end

    // Result register, shown during the done cycle
    assign capture = i_ctrl.write ||
                     (i_ctrl.tick_step && o_stat.scan_last) ||
                     (i_ctrl.next_step && o_stat.next_done);

    always_ff @(posedge i_clk) begin
        if (capture) r_result <= n_result;
    end

    assign o_result = r_result;

endmodule

// File: hdl/locomotive_state_table_top.sv
// Query and update scan the active entries, then pass a write step; tick ages
// them and next probes round-robin for a live entry. The scan visits one
// entry per cycle. A new item is taken only after the result of the last one.
// The result strobe is high for one cycle and the receiver cannot stall it.
// Synchronous active-low reset frees every entry and restores register defaults.
// ---------------------------------------------------------------------------
// locomotive_state_table_top
// Locomotive refresh table with query, update, tick and round-robin commands.
// ---------------------------------------------------------------------------
module locomotive_state_table_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  lst_pkg::t_in_item  i_item,
    output logic               o_strobe,
    output lst_pkg::t_out_item o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data
);
    import lst_pkg::*;

    t_ctrl      ctrl;
    t_stat      stat;
    logic [4:0] r_entries;
    logic [7:0] r_reload;

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= 5'd16;
            r_reload  <= 8'd20;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_ENTRIES) r_entries <= i_cfg_data[4:0];
            else                            r_reload  <= i_cfg_data;
        end
    end

    lst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    lst_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_item    (i_item),
        .i_entries (r_entries),
        .i_reload  (r_reload),
        .o_stat    (stat),
        .o_result  (o_result)
    );

    assign o_strobe = ctrl.emit;

endmodule

// File: verif/locomotive_state_table_top_tb.sv
// ---------------------------------------------------------------------------
// locomotive_state_table_top_tb
// Self-checking bench for the locomotive state table. A directed table of
// commands covers the empty table, misses, full table, claims, function
// edits, ticks and round-robin stepping; random command streams follow under
// several entry counts and timer reloads. Every result is compared field by
// field with a fixed row or a behavioral model of the table kept in the bench.
// ---------------------------------------------------------------------------
module locomotive_state_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lst_pkg::*;

    localparam int DEPTH = 16;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in_item   i_item;
    logic       o_strobe;
    t_out_item  o_result;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_index;
    logic [7:0] i_cfg_data;

    locomotive_state_table_top #(.TABLE_DEPTH(DEPTH)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_strobe(o_strobe), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Table shadow
    logic [15:0] tbl_addr  [DEPTH];
    logic [3:0]  tbl_flags [DEPTH];
    logic [7:0]  tbl_speed [DEPTH];
    logic [31:0] tbl_func  [DEPTH];
    logic [4:0]  tbl_pend  [DEPTH];
    logic [7:0]  tbl_timer [DEPTH];
    int unsigned rr_ptr;
    logic [4:0]  cnt_cfg;
    logic [7:0]  reload_cfg;

    t_out_item   pending_results[$];
    int          error_count;
    int          result_count;
    int          sender_idle_pct;

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, exp, $time);
        error_count++;
    endtask

    function automatic t_out_item entry_view(input int i, input logic [2:0] kind);
        t_out_item r;
        logic [31:0] f;
        f = tbl_func[i];
        r = '0;
        r.status = ST_OK;
        r.slot = i[3:0];
        r.out_address = tbl_addr[i];
        r.out_flags = tbl_flags[i];
        r.out_speed = tbl_speed[i];
        r.func_byte0 = {f[0], f[4:1]};
        r.func_byte1 = f[12:5];
        r.func_byte2 = f[20:13];
        r.func_byte3 = f[28:21];
        r.send_kind = kind;
        r.pending_groups = tbl_pend[i];
        return r;
    endfunction

    // Apply one command to the shadow table and return the expected result
    function automatic t_out_item table_step(input t_in_item it);
        t_out_item r;
        int n, i, pos, idx;
        logic [2:0] kind;
        bit found;
        r = '0;
        n = (cnt_cfg > DEPTH) ? DEPTH : cnt_cfg;
        i = n;
        found = 0;
        kind = KIND_NONE;
        case (t_cmd'(it.command))
            CMD_QUERY: begin
                for (int k = n - 1; k >= 0; k--)
                    if (tbl_timer[k] != 0 && tbl_addr[k] == it.loco_address) i = k;
                if (i >= n) begin
                    r.status = ST_NOTFOUND;
                    r.out_address = it.loco_address;
                    r.out_flags = 4'h2;
                    r.out_speed = 8'h80;
                end else begin
                    r = entry_view(i, KIND_NONE);
                end
            end
            CMD_UPDATE: begin
                for (int k = n - 1; k >= 0; k--)
                    if (tbl_timer[k] != 0 && tbl_addr[k] == it.loco_address) i = k;
                if (i >= n) begin
                    for (int k = n - 1; k >= 0; k--)
                        if (tbl_timer[k] == 0) i = k;
                    if (i >= n) begin
                        r.status = ST_FULL;
                        r.out_address = it.loco_address;
                        return r;
                    end
                    tbl_addr[i] = it.loco_address;
                end
                if (it.op_byte[7:4] == OP_DRIVE) begin
                    tbl_flags[i] = it.op_byte[3:0];
                    tbl_speed[i] = it.arg_byte;
                    kind = KIND_DRIVE;
                end else if (it.op_byte[7:4] == OP_FUNC) begin
                    idx = it.arg_byte[5:0];
                    kind = idx < 5 ? 3'd2 : idx < 9 ? 3'd3 : idx < 13 ? 3'd4 :
                           idx < 21 ? 3'd5 : 3'd6;
                    tbl_pend[i][kind - 2] = 1'b1;
                    if (idx < 32) begin
                        if (it.arg_byte[7]) tbl_func[i][idx] = ~tbl_func[i][idx];
                        else tbl_func[i][idx] = it.arg_byte[6];
                    end
                end
                tbl_timer[i] = reload_cfg;
                r = entry_view(i, kind);
                r.out_address = it.loco_address;
            end
            CMD_TICK: begin
                for (int k = 0; k < n; k++)
                    if (tbl_timer[k] != 0) tbl_timer[k]--;
            end
            default: begin
                pos = rr_ptr;
                for (int s = 0; s < n && !found; s++) begin
                    pos = (pos + 1 >= n) ? 0 : pos + 1;
                    if (tbl_timer[pos] != 0) found = 1;
                end
                if (found) begin
                    rr_ptr = pos;
                    r = entry_view(pos, KIND_NONE);
                end else begin
                    r.status = ST_NOLIVE;
                    r.slot = rr_ptr[3:0];
                end
            end
        endcase
        return r;
    endfunction

    // Check each strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_strobe) begin
            result_count++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", o_result.status, 0);
            end else begin
                e = pending_results.pop_front();
                if (o_result.status != e.status)
                    report_mismatch("status", o_result.status, e.status);
                if (o_result.slot != e.slot)
                    report_mismatch("slot", o_result.slot, e.slot);
                if (o_result.out_address != e.out_address)
                    report_mismatch("out_address", o_result.out_address, e.out_address);
                if (o_result.out_flags != e.out_flags)
                    report_mismatch("out_flags", o_result.out_flags, e.out_flags);
                if (o_result.out_speed != e.out_speed)
                    report_mismatch("out_speed", o_result.out_speed, e.out_speed);
                if (o_result.func_byte0 != e.func_byte0)
                    report_mismatch("func_byte0", o_result.func_byte0, e.func_byte0);
                if (o_result.func_byte1 != e.func_byte1)
                    report_mismatch("func_byte1", o_result.func_byte1, e.func_byte1);
                if (o_result.func_byte2 != e.func_byte2)
                    report_mismatch("func_byte2", o_result.func_byte2, e.func_byte2);
                if (o_result.func_byte3 != e.func_byte3)
                    report_mismatch("func_byte3", o_result.func_byte3, e.func_byte3);
                if (o_result.send_kind != e.send_kind)
                    report_mismatch("send_kind", o_result.send_kind, e.send_kind);
                if (o_result.pending_groups != e.pending_groups)
                    report_mismatch("pending_groups", o_result.pending_groups,
                                    e.pending_groups);
            end
        end
    end

    // Hand one command to the block, honoring the sender idle rate
    task automatic send_command(input t_in_item it, input bit has_fixed,
                                input t_out_item fixed);
        t_out_item e;
        while ($urandom_range(99) < sender_idle_pct) @(posedge i_clk);
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        e = table_step(it);
        if (has_fixed && e != fixed)
            report_mismatch("directed row vs model", e[31:0], fixed[31:0]);
        pending_results.push_back(has_fixed ? fixed : e);
        // Drop start and hold it low through the first busy cycle
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain results, then let the block settle before touching registers
    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_ENTRIES) cnt_cfg = val[4:0];
        else reload_cfg = val;
        @(posedge i_clk);
    endtask

    function automatic t_in_item mk(input t_cmd c, input logic [15:0] a,
                                    input logic [7:0] op, input logic [7:0] arg);
        t_in_item it;
        it.command = c;
        it.loco_address = a;
        it.op_byte = op;
        it.arg_byte = arg;
        return it;
    endfunction

    function automatic t_out_item fixed_result(input logic [1:0] st, input logic [3:0] sl,
                                               input logic [15:0] a, input logic [3:0] fl,
                                               input logic [7:0] sp);
        t_out_item r;
        r = '0;
        r.status = st;
        r.slot = sl;
        r.out_address = a;
        r.out_flags = fl;
        r.out_speed = sp;
        return r;
    endfunction

    // Random command mix; addresses drawn from a small pool to force hits
    task automatic random_phase(input int items);
        t_in_item it;
        int r;
        logic [15:0] pool [8];
        for (int k = 0; k < 8; k++) pool[k] = $urandom_range(65535);
        pool[0] = 16'hFFFF;
        pool[1] = 16'h0000;
        for (int k = 0; k < items; k++) begin
            r = $urandom_range(99);
            it.loco_address = ($urandom_range(9) == 0) ? 16'($urandom) : pool[$urandom_range(7)];
            it.arg_byte = $urandom_range(255);
            case ($urandom_range(3))
                0: it.op_byte = {OP_DRIVE, 4'($urandom_range(15))};
                1, 2: it.op_byte = {OP_FUNC, 4'($urandom_range(15))};
                default: it.op_byte = $urandom_range(255);
            endcase
            it.command = r < 25 ? CMD_QUERY : r < 65 ? CMD_UPDATE : r < 80 ? CMD_TICK : CMD_NEXT;
            send_command(it, 0, '0);
        end
    endtask

    initial begin
        t_in_item   dir_item   [$];
        bit         dir_fixed  [$];
        t_out_item  dir_result [$];
        error_count = 0;
        result_count = 0;
        sender_idle_pct = 33;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_ENTRIES;
        i_cfg_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            tbl_addr[k] = '0; tbl_flags[k] = '0; tbl_speed[k] = '0;
            tbl_func[k] = '0; tbl_pend[k] = '0; tbl_timer[k] = '0;
        end
        rr_ptr = 0;
        cnt_cfg = 5'd16;
        reload_cfg = 8'd20;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: empty table, claims, function edits, aging
        dir_item.push_back(mk(CMD_QUERY, 16'h1234, 8'h00, 8'h00));
        dir_fixed.push_back(1);
        dir_result.push_back(fixed_result(ST_NOTFOUND, 4'd0, 16'h1234, 4'h2, 8'h80));
        dir_item.push_back(mk(CMD_NEXT, 16'h0000, 8'h00, 8'h00));
        dir_fixed.push_back(1);
        dir_result.push_back(fixed_result(ST_NOLIVE, 4'd0, 16'h0000, 4'h0, 8'h00));
        dir_item.push_back(mk(CMD_TICK, 16'hFFFF, 8'hFF, 8'hFF));
        dir_fixed.push_back(1);
        dir_result.push_back('0);
        dir_item.push_back(mk(CMD_UPDATE, 16'hFFFF, 8'h1F, 8'hFF));
        dir_item.push_back(mk(CMD_UPDATE, 16'h0000, 8'h10, 8'h00));
        dir_item.push_back(mk(CMD_UPDATE, 16'hFFFF, 8'hF0, 8'h40));
        dir_item.push_back(mk(CMD_UPDATE, 16'hFFFF, 8'hF0, 8'h5F));
        dir_item.push_back(mk(CMD_UPDATE, 16'hFFFF, 8'hF0, 8'h7F));
        dir_item.push_back(mk(CMD_UPDATE, 16'hFFFF, 8'hF0, 8'h85));
        dir_item.push_back(mk(CMD_UPDATE, 16'hFFFF, 8'hF0, 8'h4C));
        dir_item.push_back(mk(CMD_UPDATE, 16'hFFFF, 8'hF0, 8'h54));
        dir_item.push_back(mk(CMD_UPDATE, 16'hFFFF, 8'hF0, 8'h1C));
        dir_item.push_back(mk(CMD_UPDATE, 16'hFFFF, 8'hF0, 8'h60));
        dir_item.push_back(mk(CMD_UPDATE, 16'h0000, 8'h55, 8'hAA));
        dir_item.push_back(mk(CMD_QUERY, 16'hFFFF, 8'h00, 8'h00));
        dir_item.push_back(mk(CMD_NEXT, 16'h0000, 8'h00, 8'h00));
        dir_item.push_back(mk(CMD_NEXT, 16'h0000, 8'h00, 8'h00));
        dir_item.push_back(mk(CMD_TICK, 16'h0000, 8'h00, 8'h00));
        dir_item.push_back(mk(CMD_QUERY, 16'h0000, 8'h00, 8'h00));
        while (dir_fixed.size() < dir_item.size()) begin
            dir_fixed.push_back(0);
            dir_result.push_back('0);
        end
        foreach (dir_item[k]) send_command(dir_item[k], dir_fixed[k], dir_result[k]);
        wait_drained();

        // Smallest table with one-tick life: full table and expiry
        write_register(REG_ENTRIES, 8'd1);
        write_register(REG_RELOAD, 8'd1);
        send_command(mk(CMD_UPDATE, 16'hA5A5, 8'h12, 8'h34), 0, '0);
        send_command(mk(CMD_UPDATE, 16'h5A5A, 8'h12, 8'h34), 1,
                     fixed_result(ST_FULL, 4'd0, 16'h5A5A, 4'h0, 8'h00));
        send_command(mk(CMD_TICK, 16'h0000, 8'h00, 8'h00), 0, '0);
        send_command(mk(CMD_QUERY, 16'hA5A5, 8'h00, 8'h00), 0, '0);
        wait_drained();

        // Zero entries and zero reload
        write_register(REG_ENTRIES, 8'd0);
        write_register(REG_RELOAD, 8'd0);
        send_command(mk(CMD_UPDATE, 16'h0001, 8'h10, 8'h01), 1,
                     fixed_result(ST_FULL, 4'd0, 16'h0001, 4'h0, 8'h00));
        send_command(mk(CMD_QUERY, 16'h0001, 8'h00, 8'h00), 0, '0);
        send_command(mk(CMD_NEXT, 16'h0001, 8'h00, 8'h00), 0, '0);
        wait_drained();

        // Random phases over several settings and idle profiles
        write_register(REG_ENTRIES, 8'd31);
        write_register(REG_RELOAD, 8'd255);
        random_phase(100);
        wait_drained();
        sender_idle_pct = 73;
        write_register(REG_ENTRIES, 8'd4);
        write_register(REG_RELOAD, 8'd3);
        random_phase(100);
        wait_drained();
        write_register(REG_RELOAD, 8'd0);
        random_phase(30);
        wait_drained();
        sender_idle_pct = 0;
        write_register(REG_ENTRIES, 8'd16);
        write_register(REG_RELOAD, 8'd6);
        random_phase(120);
        wait_drained();
        write_register(REG_ENTRIES, 8'd2);
        write_register(REG_RELOAD, 8'd2);
        random_phase(80);
        wait_drained();

        $display("Covered %0d results over entry counts 0..31 and reloads 0..255,",
                 result_count);
        $display("with query, update, tick and round-robin commands.");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
